// ===== design/tun_pkg.sv =====
// Shared types and constants for the triangle unit-normal pipeline.
// No dependencies; used by every module of the block.
package tun_pkg;

    // Number of vector components carried side by side.
    localparam int LANES = 3;

    // Width of a prescaled cross-product magnitude (largest one stays below 2^31).
    localparam int MAG_BITS = 31;

    // Per-item control that rides along with the arithmetic.
    typedef struct packed {
        logic             deg;
        logic [LANES-1:0] neg;
    } t_side;

endpackage

// ===== design/tun_front.sv =====
// Front end of the unit-normal pipeline: edges, cross product, magnitude, prescale, squares.
// Depends on tun_pkg for lane count, prescale width and the sideband struct.
module tun_front #(
    parameter int COORD_BITS  = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [9*COORD_BITS-1:0]  i_coord,
    output logic                     o_valid,
    output tun_pkg::t_side           o_side,
    output logic [2*tun_pkg::MAG_BITS-1:0] o_sq [tun_pkg::LANES],
    output logic [2*tun_pkg::MAG_BITS+1:0] o_sum
);

    localparam int L    = tun_pkg::LANES;
    localparam int MW   = tun_pkg::MAG_BITS;
    localparam int C    = COORD_BITS;
    localparam int EW   = C + 1;
    localparam int PW   = 2 * EW;
    localparam int CW   = 2 * C + 3;
    localparam int SHW  = $clog2(CW + 1);
    localparam int SQW  = 2 * MW;
    localparam int SUMW = 2 * MW + 2;
    localparam int NST  = 9;

    logic [NST-1:0] r_vld;

    logic [9*C-1:0]        r_coord;
    logic signed [EW-1:0]  r_e1 [L];
    logic signed [EW-1:0]  r_e2 [L];
    logic signed [PW-1:0]  r_p [2*L];
    logic signed [CW-1:0]  r_c [L];
    logic [CW-1:0]         r_mag [L];
    logic [CW-1:0]         r_mag6 [L];
    logic [SHW-1:0]        r_sh;
    logic [MW-1:0]         r_m [L];
    logic [SQW-1:0]        r_sq [L];
    logic [SQW-1:0]        r_sq9 [L];
    logic [SUMW-1:0]       r_sum;
    tun_pkg::t_side        r_side5, r_side6, r_side7, r_side8, r_side9;

    logic signed [C-1:0]   v [9];
    logic signed [EW-1:0]  n_e1 [L];
    logic signed [EW-1:0]  n_e2 [L];
    logic signed [PW-1:0]  n_p [2*L];
    logic signed [CW-1:0]  n_c [L];
    logic [CW-1:0]         n_mag [L];
    tun_pkg::t_side        n_side5;
    logic [CW-1:0]         orv;
    logic [SHW-1:0]        n_sh;
    logic [MW-1:0]         n_m [L];
    logic [SQW-1:0]        n_sq [L];
    logic [SUMW-1:0]       n_sum;

    // Edge vectors from vertex a
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            v[k] = r_coord[k*C +: C];
        end
        for (int i = 0; i < L; i++) begin
            n_e1[i] = EW'(v[3+i]) - EW'(v[i]);
            n_e2[i] = EW'(v[6+i]) - EW'(v[i]);
        end
    end

    // Six partial products of the cross product
    always_comb begin
        n_p[0] = r_e1[1] * r_e2[2];
        n_p[1] = r_e1[2] * r_e2[1];
        n_p[2] = r_e1[2] * r_e2[0];
        n_p[3] = r_e1[0] * r_e2[2];
        n_p[4] = r_e1[0] * r_e2[1];
        n_p[5] = r_e1[1] * r_e2[0];
    end

    always_comb begin
        for (int i = 0; i < L; i++) begin
            n_c[i] = CW'(r_p[2*i]) - CW'(r_p[2*i+1]);
        end
    end

    // Sign-magnitude split and zero detect
    always_comb begin
        n_side5.deg = 1'b1;
        for (int i = 0; i < L; i++) begin
            n_side5.neg[i] = r_c[i][CW-1];
            n_mag[i]       = r_c[i][CW-1] ? CW'(-r_c[i]) : CW'(r_c[i]);
            if (r_c[i] != '0) begin
                n_side5.deg = 1'b0;
            end
        end
    end

    // Common prescale: drop enough low bits to bring the largest below 2^MW
    always_comb begin
        orv  = r_mag[0] | r_mag[1] | r_mag[2];
        n_sh = '0;
        for (int b = 0; b < CW; b++) begin
            if (orv[b] && (b >= MW)) begin
                n_sh = SHW'(b - MW + 1);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < L; i++) begin
            n_m[i]  = MW'(r_mag6[i] >> r_sh);
            n_sq[i] = SQW'(r_m[i]) * SQW'(r_m[i]);
        end
        n_sum = SUMW'(r_sq[0]) + SUMW'(r_sq[1]) + SUMW'(r_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_coord <= i_coord;
            r_e1    <= n_e1;
            r_e2    <= n_e2;
            r_p     <= n_p;
            r_c     <= n_c;
            r_mag   <= n_mag;
            r_side5 <= n_side5;
            r_mag6  <= r_mag;
            r_sh    <= n_sh;
            r_side6 <= r_side5;
            r_m     <= n_m;
            r_side7 <= r_side6;
            r_sq    <= n_sq;
            r_side8 <= r_side7;
            r_sq9   <= r_sq;
            r_sum   <= n_sum;
            r_side9 <= r_side8;
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_side  = r_side9;
    assign o_sq    = r_sq9;
    assign o_sum   = r_sum;

endmodule

// ===== design/tun_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, three lanes sharing one divisor.
// Depends on tun_pkg for lane count and the sideband struct.
module tun_div #(
    parameter int QW   = 33,
    parameter int SQW  = 62,
    parameter int SUMW = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  tun_pkg::t_side  i_side,
    input  logic [SQW-1:0]  i_sq [tun_pkg::LANES],
    input  logic [SUMW-1:0] i_sum,
    output logic            o_valid,
    output tun_pkg::t_side  o_side,
    output logic [QW-1:0]   o_quo [tun_pkg::LANES]
);

    localparam int L = tun_pkg::LANES;

    logic [QW-1:0]   r_vld;
    tun_pkg::t_side  r_side [QW];
    logic [SUMW-1:0] r_sum  [QW];
    logic [SUMW-1:0] r_rem  [QW][L];
    logic [QW-1:0]   r_lo   [QW][L];
    logic [QW-1:0]   r_quo  [QW][L];

    // Dividend is sq * 2^(QW-1); its top part seeds the remainder, the rest shifts in
    for (genvar j = 0; j < QW; j++) begin : g_stg
        logic            src_vld;
        tun_pkg::t_side  src_side;
        logic [SUMW-1:0] src_sum;
        logic [SUMW-1:0] src_rem [L];
        logic [QW-1:0]   src_lo  [L];
        logic [QW-1:0]   src_quo [L];
        logic [SUMW-1:0] n_rem   [L];
        logic [QW-1:0]   n_lo    [L];
        logic [QW-1:0]   n_quo   [L];

        if (j == 0) begin : g_first
            always_comb begin
                src_vld  = i_valid;
                src_side = i_side;
                src_sum  = i_sum;
                for (int l = 0; l < L; l++) begin
                    src_rem[l] = SUMW'(i_sq[l] >> 1);
                    src_lo[l]  = {i_sq[l][0], {(QW-1){1'b0}}};
                    src_quo[l] = '0;
                end
            end
        end else begin : g_next
            always_comb begin
                src_vld  = r_vld[j-1];
                src_side = r_side[j-1];
                src_sum  = r_sum[j-1];
                for (int l = 0; l < L; l++) begin
                    src_rem[l] = r_rem[j-1][l];
                    src_lo[l]  = r_lo[j-1][l];
                    src_quo[l] = r_quo[j-1][l];
                end
            end
        end

        always_comb begin
            logic [SUMW:0] t;
            logic          ge;
            for (int l = 0; l < L; l++) begin
                t        = {src_rem[l], src_lo[l][QW-1]};
                ge       = (t >= {1'b0, src_sum});
                n_rem[l] = ge ? SUMW'(t - {1'b0, src_sum}) : SUMW'(t);
                n_lo[l]  = src_lo[l] << 1;
                n_quo[l] = {src_quo[l][QW-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[j] <= src_side;
                r_sum[j]  <= src_sum;
                r_rem[j]  <= n_rem;
                r_lo[j]   <= n_lo;
                r_quo[j]  <= n_quo;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_side  = r_side[QW-1];
    assign o_quo   = r_quo[QW-1];

endmodule

// ===== design/tun_sqrt.sv =====
// Pipelined digit-by-digit integer square root, one root bit per stage, three lanes.
// Depends on tun_pkg for lane count and the sideband struct.
module tun_sqrt #(
    parameter int QW = 33,
    parameter int KW = 17
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  tun_pkg::t_side i_side,
    input  logic [QW-1:0]  i_rad [tun_pkg::LANES],
    output logic           o_valid,
    output tun_pkg::t_side o_side,
    output logic [KW-1:0]  o_root [tun_pkg::LANES]
);

    localparam int L  = tun_pkg::LANES;
    localparam int RD = 2 * KW;

    logic [KW-1:0]   r_vld;
    tun_pkg::t_side  r_side [KW];
    logic [RD-1:0]   r_rad  [KW][L];
    logic [KW+1:0]   r_rem  [KW][L];
    logic [KW-1:0]   r_root [KW][L];

    for (genvar j = 0; j < KW; j++) begin : g_stg
        logic           src_vld;
        tun_pkg::t_side src_side;
        logic [RD-1:0]  src_rad  [L];
        logic [KW+1:0]  src_rem  [L];
        logic [KW-1:0]  src_root [L];
        logic [RD-1:0]  n_rad    [L];
        logic [KW+1:0]  n_rem    [L];
        logic [KW-1:0]  n_root   [L];

        if (j == 0) begin : g_first
            always_comb begin
                src_vld  = i_valid;
                src_side = i_side;
                for (int l = 0; l < L; l++) begin
                    src_rad[l]  = RD'(i_rad[l]);
                    src_rem[l]  = '0;
                    src_root[l] = '0;
                end
            end
        end else begin : g_next
            always_comb begin
                src_vld  = r_vld[j-1];
                src_side = r_side[j-1];
                for (int l = 0; l < L; l++) begin
                    src_rad[l]  = r_rad[j-1][l];
                    src_rem[l]  = r_rem[j-1][l];
                    src_root[l] = r_root[j-1][l];
                end
            end
        end

        // Bring down two radicand bits, try root*4+1
        always_comb begin
            logic [KW+3:0] t;
            logic [KW+3:0] trial;
            logic          ge;
            for (int l = 0; l < L; l++) begin
                t         = {src_rem[l], src_rad[l][RD-1 -: 2]};
                trial     = (KW+4)'({src_root[l], 2'b01});
                ge        = (t >= trial);
                n_rem[l]  = ge ? (KW+2)'(t - trial) : (KW+2)'(t);
                n_root[l] = {src_root[l][KW-2:0], ge};
                n_rad[l]  = src_rad[l] << 2;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[j] <= src_side;
                r_rad[j]  <= n_rad;
                r_rem[j]  <= n_rem;
                r_root[j] <= n_root;
            end
        end
    end

    assign o_valid = r_vld[KW-1];
    assign o_side  = r_side[KW-1];
    assign o_root  = r_root[KW-1];

endmodule

// ===== design/triangle_unit_normal.sv =====
// Top level of the triangle unit-normal block: stream ports, pipeline stall and output stage.
// Depends on tun_pkg, tun_front, tun_div and tun_sqrt.
//
// Usage:
//   Slave stream (s_axis_*) takes one face per transaction: nine signed Q12.12
//   vertex coordinates a, b, c in tdata and the too_few_vertices flag in tuser.
//   A flagged face is accepted and dropped; it produces no result.
//   Master stream (m_axis_*) gives one transaction per unflagged face: the
//   signed Q1.15 unit normal of (b-a) x (c-a) in tdata, and in tuser a flag
//   that marks a zero cross product, in which case the normal is zero.
//   Throughput: one face per cycle, sustained while the output stage is not stalled.
//   Pipeline: the front end (9 stages), the restoring divider (one quotient
//   bit per stage, 2*NORMAL_BITS+1 stages), the square root (one root bit per
//   stage, NORMAL_BITS+1 stages) and the output register, in that order.
//   Stall: while a result is held in the output register and m_axis_tready is
//   low, the whole pipeline holds and s_axis_tready drops; nothing is lost or
//   repeated. Otherwise a new face is taken every cycle.
//   Reset (i_rst_n low, synchronous) clears all valid bits; no result is
//   pending after it, and no clearing time is needed.
module triangle_unit_normal #(
    parameter int COORD_BITS  = 24,
    parameter int NORMAL_BITS = 16,
    localparam int IN_W  = ((9 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((3 * NORMAL_BITS + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    input  logic             s_axis_tuser,   // too_few_vertices
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // normal_x, normal_y, normal_z
    output logic             m_axis_tuser    // degenerate
);

    localparam int L    = tun_pkg::LANES;
    localparam int MW   = tun_pkg::MAG_BITS;
    localparam int F    = NORMAL_BITS - 1;
    localparam int QW   = 2 * F + 3;
    localparam int KW   = F + 2;
    localparam int SQW  = 2 * MW;
    localparam int SUMW = 2 * MW + 2;
    localparam logic [NORMAL_BITS-1:0] MAXPOS = NORMAL_BITS'((64'd1 << F) - 64'd1);

    logic                   en;
    logic                   fe_valid;
    tun_pkg::t_side         fe_side;
    logic [SQW-1:0]         fe_sq [L];
    logic [SUMW-1:0]        fe_sum;
    logic                   dv_valid;
    tun_pkg::t_side         dv_side;
    logic [QW-1:0]          dv_quo [L];
    logic                   sq_valid;
    tun_pkg::t_side         sq_side;
    logic [KW-1:0]          sq_root [L];

    logic                   r_out_valid;
    logic [NORMAL_BITS-1:0] r_norm [L];
    logic                   r_deg;
    logic [NORMAL_BITS-1:0] n_norm [L];

    // Advance everything unless a result sits unclaimed in the output register
    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    tun_front #(
        .COORD_BITS  (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid && !s_axis_tuser),
        .i_coord (s_axis_tdata[9*COORD_BITS-1:0]),
        .o_valid (fe_valid),
        .o_side  (fe_side),
        .o_sq    (fe_sq),
        .o_sum   (fe_sum)
    );

    // Quotient = floor(4 * m^2 * 2^(2F) / S), the squared scaled normal component
    tun_div #(
        .QW   (QW),
        .SQW  (SQW),
        .SUMW (SUMW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fe_valid),
        .i_side  (fe_side),
        .i_sq    (fe_sq),
        .i_sum   (fe_sum),
        .o_valid (dv_valid),
        .o_side  (dv_side),
        .o_quo   (dv_quo)
    );

    tun_sqrt #(
        .QW (QW),
        .KW (KW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dv_valid),
        .i_side  (dv_side),
        .i_rad   (dv_quo),
        .o_valid (sq_valid),
        .o_side  (sq_side),
        .o_root  (sq_root)
    );

    // Root k = floor(2*|n|*2^F / sqrt(S)); the rounded magnitude is (k+1)/2.
    // Apply sign, clamp the positive full-scale value, zero a degenerate face.
    always_comb begin
        logic [KW:0]   kp1;
        logic [KW-1:0] mag;
        for (int i = 0; i < L; i++) begin
            kp1 = {1'b0, sq_root[i]} + (KW+1)'(1);
            mag = kp1[KW:1];
            if (sq_side.deg) begin
                n_norm[i] = '0;
            end else if (sq_side.neg[i]) begin
                n_norm[i] = NORMAL_BITS'(-mag);
            end else if (mag > KW'(MAXPOS)) begin
                n_norm[i] = MAXPOS;
            end else begin
                n_norm[i] = NORMAL_BITS'(mag);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_norm <= n_norm;
            r_deg  <= sq_side.deg;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_norm[2], r_norm[1], r_norm[0]});
    assign m_axis_tuser  = r_deg;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for triangle_unit_normal: random and directed faces in,
// unit normals checked against an exact integer predictor. Depends on tun_pkg and the block.
module testbench;

    localparam int CB = 24;
    localparam int NB = 16;
    localparam int IN_W = ((9 * CB + 7) / 8) * 8;
    localparam int OUT_W = ((3 * NB + 7) / 8) * 8;
    localparam int LATENCY = 3 * NB + 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

    typedef struct {
        logic signed [NB-1:0] nx, ny, nz;
        logic                 deg;
    } t_normal;

    logic             i_clk = 0;
    logic             i_rst_n = 0;
    logic             s_axis_tvalid = 0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    logic             s_axis_tuser = 0;    // too_few_vertices
    logic             m_axis_tvalid;
    logic             m_axis_tready = 0;
    logic [OUT_W-1:0] m_axis_tdata;        // normal_x, normal_y, normal_z
    logic             m_axis_tuser;        // degenerate

    t_normal normals_due[$];
    int      mismatches = 0;
    int      faces_sent = 0;
    int      normals_seen = 0;
    int      idle_cycles = 0;
    bit      gaps_on = 1;

    triangle_unit_normal DUT (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Exact root scaling: largest r <= 2^F with (2r-1)^2 * s <= c^2 * 2^(2F+2).
    function automatic logic [NB-1:0] root_scale(logic [63:0] c, logic [127:0] s);
        logic [127:0] target;
        logic [127:0] odd;
        longint unsigned lo, hi, mid;
        target = (128'(c) * 128'(c)) << (2 * (NB - 1) + 2);
        lo = 0;
        hi = 64'd1 << (NB - 1);
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            odd = 128'(2 * mid - 1);
            if (odd * odd * s <= target) lo = mid;
            else hi = mid - 1;
        end
        return lo[NB-1:0];
    endfunction

    function automatic t_normal face_normal(logic [IN_W-1:0] d);
        logic signed [CB-1:0]  v[9];
        logic signed [127:0]   e1[3], e2[3], cr[3];
        logic [127:0]          mag[3], top, sum;
        logic [63:0]           m;
        logic [NB-1:0]         r;
        logic [NB-1:0]         res[3];
        int                    sh;
        t_normal               n;
        for (int i = 0; i < 9; i++) v[i] = d[i*CB +: CB];
        for (int i = 0; i < 3; i++) begin
            e1[i] = 128'(v[3+i]) - 128'(v[i]);
            e2[i] = 128'(v[6+i]) - 128'(v[i]);
        end
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        top = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
            if (mag[i] > top) top = mag[i];
        end
        if (top == 0) begin
            n.nx = 0; n.ny = 0; n.nz = 0; n.deg = 1;
            return n;
        end
        sh = 0;
        while ((top >> sh) >= 128'h8000_0000) sh++;
        sum = 0;
        for (int i = 0; i < 3; i++) sum += (mag[i] >> sh) * (mag[i] >> sh);
        for (int i = 0; i < 3; i++) begin
            m = 64'(mag[i] >> sh);
            r = root_scale(m, sum);
            // Negative full scale is representable; positive full scale saturates.
            if (cr[i] < 0) res[i] = -r;
            else res[i] = (r[NB-1]) ? {1'b0, {(NB-1){1'b1}}} : r;
        end
        n.nx = res[0]; n.ny = res[1]; n.nz = res[2]; n.deg = 0;
        return n;
    endfunction

    // Hold a face on the slave stream until the transaction completes.
    // Drop tvalid only when a gap follows; stop_input ends a stream of faces.
    task automatic send_face(logic flag, logic signed [CB-1:0] c[9]);
        logic [IN_W-1:0] d;
        int gap;
        d = '0;
        for (int i = 0; i < 9; i++) d[i*CB +: CB] = c[i];
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= flag;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (!flag) normals_due = {normals_due, face_normal(d)};
        faces_sent++;
    endtask

    // Drop tvalid and wait for a clock edge before anything else drives it.
    task automatic stop_input();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [CB-1:0] rand_coord(int mode);
        case (mode)
            0: return CB'($urandom);
            1: return CB'($signed($urandom_range(0, 8192)) - 4096);
            2: return ($urandom_range(0, 1)) ? CMAX : CMIN;
            default: return CB'($signed($urandom_range(0, 16)) - 8);
        endcase
    endfunction

    task automatic test_extremes();
        logic signed [CB-1:0] c[9];
        // Axis-aligned unit triangle: normal along +z, saturated at full scale.
        c = '{0, 0, 0, 4096, 0, 0, 0, 4096, 0};
        send_face(0, c);
        // Reverse winding: normal along -z, exactly -1.0.
        c = '{0, 0, 0, 0, 4096, 0, 4096, 0, 0};
        send_face(0, c);
        // Coincident vertices give a degenerate face.
        c = '{5, 6, 7, 5, 6, 7, 5, 6, 7};
        send_face(0, c);
        // Collinear vertices, also degenerate.
        c = '{0, 0, 0, 1, 2, 3, 2, 4, 6};
        send_face(0, c);
        // Coordinate extremes: largest cross products, forces prescale.
        c = '{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN};
        send_face(0, c);
        c = '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN};
        send_face(0, c);
        c = '{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX};
        send_face(0, c);
        // Diagonal normal: all components equal, tests rounding.
        c = '{0, 0, 0, 4096, -4096, 0, 0, 4096, -4096};
        send_face(0, c);
        // Flagged faces, with and without meaningful coordinates.
        send_face(1, c);
        c = '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX};
        send_face(1, c);
        // Tiny triangle near the origin.
        c = '{0, 0, 0, 1, 0, 0, 0, 0, 1};
        send_face(0, c);
        c = '{-1, -1, -1, 0, -1, -1, -1, 0, -1};
        send_face(0, c);
        stop_input();
    endtask

    task automatic test_random(int count);
        logic signed [CB-1:0] c[9];
        int mode;
        for (int k = 0; k < count; k++) begin
            mode = $urandom_range(0, 3);
            for (int i = 0; i < 9; i++) c[i] = rand_coord(mode);
            // Drop in a coincident pair now and then.
            if ($urandom_range(0, 15) == 0) for (int i = 0; i < 3; i++) c[3+i] = c[i];
            send_face($urandom_range(0, 9) == 0, c);
        end
        stop_input();
    endtask

    // Back-to-back faces with no gaps, then drain before moving on.
    task automatic test_burst_and_drain(int count);
        gaps_on = 0;
        test_random(count);
        gaps_on = 1;
        while (normals_due.size() != 0) @(posedge i_clk);
    endtask

    // Master side: random stalls, with stall-free stretches.
    initial begin
        int wait_n;
        forever begin
            @(posedge i_clk);
            if (m_axis_tready && m_axis_tvalid) begin
                m_axis_tready <= 0;
                wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
                repeat (wait_n) @(posedge i_clk);
                m_axis_tready <= 1;
            end else if (!m_axis_tready) begin
                m_axis_tready <= 1;
            end
        end
    end

    // Compare each normal with the oldest one due.
    always @(posedge i_clk) begin
        t_normal got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.nx  = m_axis_tdata[0 +: NB];
            got.ny  = m_axis_tdata[NB +: NB];
            got.nz  = m_axis_tdata[2*NB +: NB];
            got.deg = m_axis_tuser;
            normals_seen++;
            if (normals_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected normal %p", got);
            end else begin
                want = normals_due.pop_front();
                if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz ||
                    got.deg !== want.deg) begin
                    mismatches++;
                    if (mismatches <= 10) $display("normal %0d: expected %p, got %p",
                                                   normals_seen, want, got);
                end
            end
        end
    end

    // Watchdog: count cycles with no transaction on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        test_extremes();
        test_burst_and_drain(200);
        test_random(1650);
        while (normals_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("covered %0d faces, %0d normals checked, incl. flagged and degenerate faces",
                 faces_sent, normals_seen);
        if (mismatches == 0 && normals_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
